// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/dtes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_pkg
// Widths, constants, command/status types and helper functions for the
// date to epoch seconds converter.
// ----------------------------------------------------------------------------
package dtes_pkg;

	// Field widths
	localparam int YEAR_W  = 12;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int ZONE_W  = 17;
	localparam int SECS_W  = 32;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 3;
	// Day count: 4095 years of 366 days plus one year of days fits in 21 bits
	localparam int DAYS_W  = 21;
	localparam int CUM_W   = 9;
	localparam int TOD_W   = 17;
	localparam int SPD_W   = 17;

	// Register index codes (word address bit 2)
	localparam logic REG_REF_YEAR = 1'b0;
	localparam logic REG_DEF_ZONE = 1'b1;

	// Reset values
	localparam logic [YEAR_W-1:0] REF_YEAR_RST = 12'd1970;
	localparam logic [ZONE_W-1:0] DEF_ZONE_RST = '0;

	// Calendar and time constants
	localparam logic [CUM_W-1:0]   DAYS_PER_YEAR = 9'd365;
	localparam logic [SPD_W-1:0]   SECS_PER_DAY  = 17'd86400;
	localparam logic [TOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
	localparam logic [TOD_W-1:0]   SECS_PER_MIN  = 17'd60;
	localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_MAR     = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;

	// Year / 100 by reciprocal: floor(y * 5243 / 2^19) is exact below 4096
	localparam int          RECIP_W     = 13;
	localparam int          RECIP_SHIFT = 19;
	localparam int          RPROD_W     = YEAR_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam logic [YEAR_W+1:0]  CENTURY   = 14'd100;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic year_step;
		logic month_step;
		logic mul_step;
		logic sum_step;
	} dtes_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic years_done;
	} dtes_stat_t;

	// Gregorian leap test: divisible by 4, not by 100 unless by 400
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [RPROD_W-1:0]  prod;
		logic [RPROD_W-RECIP_SHIFT-1:0] q;
		logic [YEAR_W+1:0]   q100;
		logic                cent;
		prod = RPROD_W'(y) * RPROD_W'(RECIP_100);
		q    = prod[RPROD_W-1:RECIP_SHIFT];
		q100 = (YEAR_W+2)'(q) * CENTURY;
		cent = ((YEAR_W+2)'(y) == q100);
		return (y[1:0] == 2'd0) && (!cent || (q[1:0] == 2'd0));
	endfunction

	// Days before the first of a month (month already limited to 1..12)
	function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
		logic [CUM_W-1:0] d;
		unique case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/core/dtes_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_regs
// APB-style register file: reference year and default zone offset.
// ----------------------------------------------------------------------------
module dtes_regs import dtes_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	output logic [YEAR_W-1:0]        ref_year,
	output logic signed [ZONE_W-1:0] def_zone
);

	logic [YEAR_W-1:0] ref_year_q;
	logic [ZONE_W-1:0] def_zone_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_year_q <= REF_YEAR_RST;
			def_zone_q <= DEF_ZONE_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_REF_YEAR: ref_year_q <= pwdata[YEAR_W-1:0];
				REG_DEF_ZONE: def_zone_q <= pwdata[ZONE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (paddr[2])
			REG_REF_YEAR: prdata = DATA_W'(ref_year_q);
			REG_DEF_ZONE: prdata = DATA_W'(def_zone_q);
			default:      prdata = '0;
		endcase
	end

	assign ref_year = ref_year_q;
	assign def_zone = def_zone_q;

endmodule

// ----- rtl/core/dtes_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_ctrl
// Controller: sequences load, year loop, month add, multiply and final sum,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module dtes_ctrl import dtes_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dtes_stat_t stat,
	output dtes_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_YEARS = 5'b00010,
		ST_MONTH = 5'b00100,
		ST_MUL   = 5'b01000,
		ST_SUM   = 5'b10000
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	// Output register can take a beat when empty or being drained
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.load       = (state_q == ST_IDLE) && in_valid;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_YEARS;
			end
			ST_YEARS: begin
				cmd.year_step = 1'b1;
				if (stat.years_done) state_nxt = ST_MONTH;
			end
			ST_MONTH: begin
				cmd.month_step = 1'b1;
				state_nxt      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				state_nxt    = ST_SUM;
			end
			ST_SUM: begin
				if (out_free) begin
					cmd.sum_step = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.sum_step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/dtes_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_dp
// Datapath: item registers, year counter with day accumulator, month and
// day add, seconds multiply and the output register.
// ----------------------------------------------------------------------------
module dtes_dp import dtes_pkg::*; (
	input  logic                     clk,
	input  dtes_cmd_t                cmd,
	output dtes_stat_t               stat,
	input  logic [YEAR_W-1:0]        ref_year,
	input  logic signed [ZONE_W-1:0] def_zone,
	input  logic [YEAR_W-1:0]        year,
	input  logic [MONTH_W-1:0]       month,
	input  logic [DAY_W-1:0]         day,
	input  logic [HOUR_W-1:0]        hour,
	input  logic [MIN_W-1:0]         minute,
	input  logic [SEC_W-1:0]         second,
	input  logic signed [ZONE_W-1:0] zone_offset,
	output logic [SECS_W-1:0]        epoch_seconds
);

	logic [YEAR_W-1:0]        y_q, year_q;
	logic [MONTH_W-1:0]       month_q;
	logic [DAY_W-1:0]         day_q;
	logic [HOUR_W-1:0]        hour_q;
	logic [MIN_W-1:0]         minute_q;
	logic [SEC_W-1:0]         second_q;
	logic signed [ZONE_W-1:0] zone_q;
	logic [DAYS_W-1:0]        days_q;
	logic [SECS_W-1:0]        prod_q, tod_q, epoch_q;

	logic [MONTH_W-1:0]       month_n;
	logic [CUM_W-1:0]         year_days;
	logic [CUM_W-1:0]         month_days;
	logic [DAY_W-1:0]         day_adj;
	logic                     leap_extra;
	logic [DAYS_W+SPD_W-1:0]  day_secs;
	logic [TOD_W-1:0]         tod_secs;

	assign stat.years_done = !(y_q < year_q);

	// Length of the year under the counter
	assign year_days = DAYS_PER_YEAR + CUM_W'(is_leap(y_q));

	// Month limited to January..December, then whole-month days
	always_comb begin
		priority if (month_q == '0)       month_n = MONTH_JAN;
		else if (month_q > MONTH_DEC)     month_n = MONTH_DEC;
		else                              month_n = month_q;
	end
	assign month_days = cum_days(month_n);
	assign leap_extra = (month_n >= MONTH_MAR) && is_leap(year_q);
	assign day_adj    = (day_q == '0) ? '0 : day_q - DAY_W'(1);

	// Seconds from days and from time of day
	assign day_secs = (DAYS_W+SPD_W)'(days_q) * (DAYS_W+SPD_W)'(SECS_PER_DAY);
	assign tod_secs = TOD_W'(hour_q) * SECS_PER_HOUR + TOD_W'(minute_q) * SECS_PER_MIN
		+ TOD_W'(second_q);

	always_ff @(posedge clk) begin
		// Item capture and zone selection
		if (cmd.load) begin
			y_q      <= ref_year;
			year_q   <= year;
			month_q  <= month;
			day_q    <= day;
			hour_q   <= hour;
			minute_q <= minute;
			second_q <= second;
			zone_q   <= (zone_offset != '0) ? zone_offset : def_zone;
			days_q   <= '0;
		end
		// One whole year per cycle
		if (cmd.year_step && !stat.years_done) begin
			days_q <= days_q + DAYS_W'(year_days);
			y_q    <= y_q + YEAR_W'(1);
		end
		// Whole months, leap day and day of month
		if (cmd.month_step) begin
			days_q <= days_q + DAYS_W'(month_days) + DAYS_W'(leap_extra)
				+ DAYS_W'(day_adj);
		end
		// Day seconds and time-of-day plus zone, kept modulo 2^32
		if (cmd.mul_step) begin
			prod_q <= day_secs[SECS_W-1:0];
			tod_q  <= SECS_W'(tod_secs)
				+ {{(SECS_W-ZONE_W){zone_q[ZONE_W-1]}}, zone_q};
		end
		// Output register
		if (cmd.sum_step) begin
			epoch_q <= prod_q + tod_q;
		end
	end

	assign epoch_seconds = epoch_q;

endmodule

// ----- rtl/core/date_to_epoch_seconds_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_to_epoch_seconds_core
// Civil date and time of day to seconds since the start of a reference year.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Beat contents
//  ---------+------------------------+-------------------------------------------
//  input    | in_valid / in_ready    | year month day hour minute second zone_offset
//  output   | out_valid / out_ready  | epoch_seconds
//  config   | psel penable pwrite    | reference_year @0x0, default_zone_offset @0x4
//
//  One item at a time; the year loop adds one year of days per cycle for
//  n = max(0, year - reference_year) years, then month, multiply and sum steps.
//  The output register holds a result while out_ready is low; the next input
//  beat is taken meanwhile and waits in the final sum until the register frees.
//  Reset restores reference year 1970 and default zone 0; no clearing pass.
// ----------------------------------------------------------------------------
module date_to_epoch_seconds_core import dtes_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// Input channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [YEAR_W-1:0]        year,
	input  logic [MONTH_W-1:0]       month,
	input  logic [DAY_W-1:0]         day,
	input  logic [HOUR_W-1:0]        hour,
	input  logic [MIN_W-1:0]         minute,
	input  logic [SEC_W-1:0]         second,
	input  logic signed [ZONE_W-1:0] zone_offset,
	// Output channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SECS_W-1:0]        epoch_seconds,
	// Configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

	dtes_cmd_t                cmd;
	dtes_stat_t               stat;
	logic [YEAR_W-1:0]        ref_year;
	logic signed [ZONE_W-1:0] def_zone;

	// Configuration registers
	dtes_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.ref_year (ref_year),
		.def_zone (def_zone)
	);

	// Sequencer
	dtes_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Arithmetic
	dtes_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.stat          (stat),
		.ref_year      (ref_year),
		.def_zone      (def_zone),
		.year          (year),
		.month         (month),
		.day           (day),
		.hour          (hour),
		.minute        (minute),
		.second        (second),
		.zone_offset   (zone_offset),
		.epoch_seconds (epoch_seconds)
	);

endmodule

// ----- rtl/core/dtes_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtes_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtes_checker import dtes_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [SECS_W-1:0] epoch_seconds,
	input logic              pready
);

	// Held result stays put
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(epoch_seconds), "result changed while stalled")
	// One item in flight: busy right after an input beat
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "second beat taken while busy")
	// A result never appears the cycle after an input beat
	`ASSERT_IMPLY(a_no_early_result, clk, arst_n, $rose(out_valid), !$past(in_valid && in_ready), "result too early")
	// Config port never stalls
	`ASSERT_IMPLY(a_pready_high, clk, arst_n, 1'b1, pready, "pready low")

endmodule

bind date_to_epoch_seconds_core dtes_checker u_dtes_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.epoch_seconds (epoch_seconds),
	.pready        (pready)
);
